// ===== hdl/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared constants and types for the HSL to RGB colour converter: hue
// geometry, the reciprocal multipliers that replace constant divisions,
// and the hue sector encoding.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    // Default number of internal fraction bits.
    localparam int FRACTION_BITS_DEF = 16;

    // Hue geometry in sixteenths of a degree.
    localparam int HUE_FULL   = 5760;
    localparam int HUE_SECTOR = 960;
    // Multiple of both HUE_FULL and HUE_SECTOR that lifts any 16-bit signed hue
    // above zero without changing it modulo either.
    localparam int HUE_BIAS   = 34560;

    // Division of an 11-bit value by 15: multiply and shift right.
    localparam int DIV15_NARROW_MUL   = 4370;
    localparam int DIV15_NARROW_SHIFT = 16;
    // Division of a value below 2^28.19 by 15: multiply and shift right.
    localparam int DIV15_WIDE_MUL     = 286331154;
    localparam int DIV15_WIDE_SHIFT   = 32;
    // Division of a 7-bit value by 6: multiply and shift right.
    localparam int DIV6_MUL           = 43;
    localparam int DIV6_SHIFT         = 8;

    // Largest byte value.
    localparam logic [7:0] BYTE_MAX = 8'hFF;

    // Sixty-degree hue sectors, in the order they appear around the wheel.
    typedef enum logic [2:0] {
        SECT_RED_YELLOW     = 3'd0,
        SECT_YELLOW_GREEN   = 3'd1,
        SECT_GREEN_CYAN     = 3'd2,
        SECT_CYAN_BLUE      = 3'd3,
        SECT_BLUE_MAGENTA   = 3'd4,
        SECT_MAGENTA_RED    = 3'd5
    } sector_t;

endpackage

// ===== hdl/hsl_to_rgb_convert_unit.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_convert_unit
// Converts one HSLA colour per item into an 8-bit ARGB colour.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on the s_ channel: hue is a signed angle in sixteenths of a
// degree (any value, wrapped modulo 360 degrees); saturation, lightness and
// alpha are unsigned Q0.16 fractions where the all-ones code means one.
// Each item leaves on the m_ channel as four bytes: alpha, red, green, blue.
// Every input item gives exactly one result item, in order.
// Throughput is one item per cycle unless a result waits with m_tready low;
// the six register stages (hue wrap, chroma multiply, secondary multiply,
// divide-by-960 reciprocal multiply, sector select, scale by 255) each
// hold one item, and the last stage is the output register.
// When the receiver holds m_tready low with a result waiting, every stage
// holds its item and s_tready drops in the same cycle, so nothing is lost
// or repeated; empty stages are never skipped over.
// Reset (aresetn low at a clock edge) empties the pipeline; the block keeps
// no other state.
// ----------------------------------------------------------------------------
module hsl_to_rgb_convert_unit
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] hue, [31:16] saturation, [47:32] lightness, [63:48] alpha_in
    input  logic [63:0] s_tdata,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] alpha_out, [15:8] red, [23:16] green, [31:24] blue
    output logic [31:0] m_tdata
);

    localparam int F       = FRACTION_BITS;
    localparam int VW      = F + 1;          // values from zero to one
    localparam int TW      = F + 2;          // twice a value
    localparam int SW      = F + 3;          // channel sum before scaling
    localparam int NSTAGES = 6;

    localparam logic [VW-1:0] ONE = VW'(1) << F;

    // Pipeline control: the whole pipe advances unless a result waits.
    logic               adv;
    logic [NSTAGES-1:0] valid_reg;
    logic [NSTAGES-1:0] valid_next;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[NSTAGES-1];

    assign valid_next = {valid_reg[NSTAGES-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: widen fractions, lightness distance, hue bias and coarse
    // division of the hue by 960, alpha byte.
    // ------------------------------------------------------------------
    logic [15:0]   hue_in;
    logic [16:0]   sat_ext;
    logic [16:0]   light_ext;
    logic [16:0]   alpha_ext;
    logic [VW-1:0] sat_w;
    logic [VW-1:0] light_w;
    logic [VW-1:0] alpha_w;
    logic [TW-1:0] twol;
    logic [VW-1:0] light_dist;
    logic [10:0]   hue_hi;
    logic [23:0]   hue_div_prod;
    logic [VW+7:0] alpha_prod;
    logic [8:0]    alpha_scaled;

    logic [VW-1:0] sat1_reg,   sat1_next;
    logic [TW-1:0] twol1_reg,  twol1_next;
    logic [VW-1:0] omd1_reg,   omd1_next;
    logic [16:0]   hpos1_reg,  hpos1_next;
    logic [6:0]    hq1_reg,    hq1_next;
    logic [7:0]    ab1_reg,    ab1_next;

    always_comb begin
        hue_in    = s_tdata[15:0];
        sat_ext   = (s_tdata[31:16] == 16'hFFFF) ? 17'h10000 : {1'b0, s_tdata[31:16]};
        light_ext = (s_tdata[47:32] == 16'hFFFF) ? 17'h10000 : {1'b0, s_tdata[47:32]};
        alpha_ext = (s_tdata[63:48] == 16'hFFFF) ? 17'h10000 : {1'b0, s_tdata[63:48]};
        sat_w     = VW'(({{F{1'b0}}, sat_ext} << F) >> 16);
        light_w   = VW'(({{F{1'b0}}, light_ext} << F) >> 16);
        alpha_w   = VW'(({{F{1'b0}}, alpha_ext} << F) >> 16);

        // Distance of twice the lightness from one.
        twol = {light_w, 1'b0};
        if (twol >= TW'(ONE)) begin
            light_dist = VW'(twol - TW'(ONE));
        end else begin
            light_dist = VW'(TW'(ONE) - twol);
        end

        // Biased hue is positive; divide by 960 as a shift by 6 then by 15.
        hpos1_next   = {hue_in[15], hue_in} + 17'(HUE_BIAS);
        hue_hi       = hpos1_next[16:6];
        hue_div_prod = 24'(hue_hi) * 24'(DIV15_NARROW_MUL);
        hq1_next     = hue_div_prod[DIV15_NARROW_SHIFT +: 7];

        alpha_prod   = (VW+8)'(alpha_w) * (VW+8)'(255);
        alpha_scaled = alpha_prod[F +: 9];
        ab1_next     = alpha_scaled[8] ? BYTE_MAX : alpha_scaled[7:0];

        sat1_next  = sat_w;
        twol1_next = twol;
        omd1_next  = ONE - light_dist;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sat1_reg  <= sat1_next;
            twol1_reg <= twol1_next;
            omd1_reg  <= omd1_next;
            hpos1_reg <= hpos1_next;
            hq1_reg   <= hq1_next;
            ab1_reg   <= ab1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: chroma, position inside the sector and the sector itself.
    // ------------------------------------------------------------------
    logic [2*VW-1:0] chroma_prod;
    logic [10:0]     sect_rem;
    logic [11:0]     div6_prod;
    logic [3:0]      wraps;

    logic [VW-1:0] c2_reg,    c2_next;
    logic [TW-1:0] twol2_reg, twol2_next;
    logic [9:0]    pos2_reg,  pos2_next;
    sector_t       sect2_reg, sect2_next;
    logic [7:0]    ab2_reg,   ab2_next;

    always_comb begin
        chroma_prod = (2*VW)'(omd1_reg) * (2*VW)'(sat1_reg);
        c2_next     = chroma_prod[F +: VW];

        // Remainder of the coarse division gives the top bits of the position.
        sect_rem  = hpos1_reg[16:6] - 11'(hq1_reg) * 11'd15;
        pos2_next = {sect_rem[3:0], hpos1_reg[5:0]};

        // Sector number is the quotient modulo six.
        div6_prod  = 12'(hq1_reg) * 12'(DIV6_MUL);
        wraps      = div6_prod[DIV6_SHIFT +: 4];
        sect2_next = sector_t'(3'(hq1_reg - 7'(wraps) * 7'd6));

        twol2_next = twol1_reg;
        ab2_next   = ab1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c2_reg    <= c2_next;
            twol2_reg <= twol2_next;
            pos2_reg  <= pos2_next;
            sect2_reg <= sect2_next;
            ab2_reg   <= ab2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: triangle-wave weight, chroma times weight, doubled offset.
    // ------------------------------------------------------------------
    logic [9:0] weight;

    logic [VW+9:0] p3_reg,    p3_next;
    logic [VW-1:0] c3_reg,    c3_next;
    logic [TW-1:0] m3_reg,    m3_next;
    sector_t       sect3_reg, sect3_next;
    logic [7:0]    ab3_reg,   ab3_next;

    always_comb begin
        // Odd sectors run the weight downwards.
        if (sect2_reg[0]) begin
            weight = 10'(HUE_SECTOR) - pos2_reg;
        end else begin
            weight = pos2_reg;
        end
        p3_next = (VW+10)'(c2_reg) * (VW+10)'(weight);

        if (twol2_reg >= TW'(c2_reg)) begin
            m3_next = twol2_reg - TW'(c2_reg);
        end else begin
            m3_next = '0;
        end

        c3_next    = c2_reg;
        sect3_next = sect2_reg;
        ab3_next   = ab2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_reg    <= p3_next;
            c3_reg    <= c3_next;
            m3_reg    <= m3_next;
            sect3_reg <= sect3_next;
            ab3_reg   <= ab3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: secondary component, product divided by 960 as a shift by
    // 6 and a reciprocal multiply by 1/15.
    // ------------------------------------------------------------------
    logic [VW+3:0]  p_shr;
    logic [VW+32:0] x_prod;

    logic [VW-1:0] x4_reg,    x4_next;
    logic [VW-1:0] c4_reg,    c4_next;
    logic [TW-1:0] m4_reg,    m4_next;
    sector_t       sect4_reg, sect4_next;
    logic [7:0]    ab4_reg,   ab4_next;

    always_comb begin
        p_shr      = p3_reg[VW+9:6];
        x_prod     = (VW+33)'(p_shr) * (VW+33)'(DIV15_WIDE_MUL);
        x4_next    = x_prod[DIV15_WIDE_SHIFT +: VW];
        c4_next    = c3_reg;
        m4_next    = m3_reg;
        sect4_next = sect3_reg;
        ab4_next   = ab3_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x4_reg    <= x4_next;
            c4_reg    <= c4_next;
            m4_reg    <= m4_next;
            sect4_reg <= sect4_next;
            ab4_reg   <= ab4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: place chroma and secondary by sector, add the offset.
    // ------------------------------------------------------------------
    logic [VW-1:0] comp_r;
    logic [VW-1:0] comp_g;
    logic [VW-1:0] comp_b;

    logic [SW-1:0] sum_r5_reg, sum_r5_next;
    logic [SW-1:0] sum_g5_reg, sum_g5_next;
    logic [SW-1:0] sum_b5_reg, sum_b5_next;
    logic [7:0]    ab5_reg,    ab5_next;

    always_comb begin
        case (sect4_reg)
            SECT_RED_YELLOW: begin
                comp_r = c4_reg; comp_g = x4_reg; comp_b = '0;
            end
            SECT_YELLOW_GREEN: begin
                comp_r = x4_reg; comp_g = c4_reg; comp_b = '0;
            end
            SECT_GREEN_CYAN: begin
                comp_r = '0;     comp_g = c4_reg; comp_b = x4_reg;
            end
            SECT_CYAN_BLUE: begin
                comp_r = '0;     comp_g = x4_reg; comp_b = c4_reg;
            end
            SECT_BLUE_MAGENTA: begin
                comp_r = x4_reg; comp_g = '0;     comp_b = c4_reg;
            end
            default: begin
                comp_r = c4_reg; comp_g = '0;     comp_b = x4_reg;
            end
        endcase
        sum_r5_next = {1'b0, comp_r, 1'b0} + SW'(m4_reg);
        sum_g5_next = {1'b0, comp_g, 1'b0} + SW'(m4_reg);
        sum_b5_next = {1'b0, comp_b, 1'b0} + SW'(m4_reg);
        ab5_next    = ab4_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_r5_reg <= sum_r5_next;
            sum_g5_reg <= sum_g5_next;
            sum_b5_reg <= sum_b5_next;
            ab5_reg    <= ab5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6 (output register): scale by 255 and truncate to bytes.
    // ------------------------------------------------------------------
    logic [SW+7:0] scaled_r;
    logic [SW+7:0] scaled_g;
    logic [SW+7:0] scaled_b;

    logic [7:0] red6_reg,   red6_next;
    logic [7:0] green6_reg, green6_next;
    logic [7:0] blue6_reg,  blue6_next;
    logic [7:0] ab6_reg,    ab6_next;

    always_comb begin
        scaled_r = (SW+8)'(sum_r5_reg) * (SW+8)'(255);
        scaled_g = (SW+8)'(sum_g5_reg) * (SW+8)'(255);
        scaled_b = (SW+8)'(sum_b5_reg) * (SW+8)'(255);
        // Anything above a byte saturates.
        red6_next   = (scaled_r[F+1 +: 10] > 10'(BYTE_MAX)) ? BYTE_MAX
                                                            : scaled_r[F+1 +: 8];
        green6_next = (scaled_g[F+1 +: 10] > 10'(BYTE_MAX)) ? BYTE_MAX
                                                            : scaled_g[F+1 +: 8];
        blue6_next  = (scaled_b[F+1 +: 10] > 10'(BYTE_MAX)) ? BYTE_MAX
                                                            : scaled_b[F+1 +: 8];
        ab6_next    = ab5_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red6_reg   <= red6_next;
            green6_reg <= green6_next;
            blue6_reg  <= blue6_next;
            ab6_reg    <= ab6_next;
        end
    end

    assign m_tdata = {blue6_reg, green6_reg, red6_reg, ab6_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Reset leaves the pipeline empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (valid_reg == '0))
        else $error("pipeline not empty after reset");

    // A held result freezes every stage's occupancy.
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(valid_reg))
        else $error("pipeline moved while the output was stalled");

    // An accepted item occupies the first stage on the next cycle.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted item did not enter the pipeline");

endmodule
